// ===== hdl/asp_pkg.sv =====
// ============================================================================
// ANSI escape sequence parser package
// Shared types, command codes and color helpers for the parser blocks.
// ============================================================================
package asp_pkg;

    localparam int unsigned CMD_W   = 5;
    localparam int unsigned ARG_W   = 16;
    localparam int unsigned GLYPH_W = 7;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned DIM_W   = 12;

    localparam logic [CMD_W-1:0] CMD_GLYPH   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_CR      = 5'd1;
    localparam logic [CMD_W-1:0] CMD_NL      = 5'd2;
    localparam logic [CMD_W-1:0] CMD_BS      = 5'd3;
    localparam logic [CMD_W-1:0] CMD_TAB     = 5'd4;
    localparam logic [CMD_W-1:0] CMD_ED      = 5'd5;
    localparam logic [CMD_W-1:0] CMD_EL      = 5'd6;
    localparam logic [CMD_W-1:0] CMD_UP      = 5'd7;
    localparam logic [CMD_W-1:0] CMD_DOWN    = 5'd8;
    localparam logic [CMD_W-1:0] CMD_RIGHT   = 5'd9;
    localparam logic [CMD_W-1:0] CMD_LEFT    = 5'd10;
    localparam logic [CMD_W-1:0] CMD_COLUMN  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_ROW     = 5'd12;
    localparam logic [CMD_W-1:0] CMD_POS     = 5'd13;
    localparam logic [CMD_W-1:0] CMD_NEXTLN  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_REPEAT  = 5'd15;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_DELCH   = 5'd17;
    localparam logic [CMD_W-1:0] CMD_DELLN   = 5'd18;
    localparam logic [CMD_W-1:0] CMD_SIZE    = 5'd19;
    localparam logic [CMD_W-1:0] CMD_ATTR    = 5'd20;

    localparam logic [0:0] REG_COLUMNS = 1'b0;
    localparam logic [0:0] REG_ROWS    = 1'b1;

    localparam logic [GLYPH_W-1:0] GLYPH_UNKNOWN = 7'h3F;
    localparam logic [RGB_W-1:0]   FG_DEFAULT    = 24'hC0C0C0;
    localparam logic [RGB_W-1:0]   BG_DEFAULT    = 24'h000000;

    typedef enum logic [2:0] {
        PH_GROUND,
        PH_ESC,
        PH_SKIP,
        PH_PARAM,
        PH_INTER,
        PH_WALK
    } phase_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_GROUND,
        EM_QMARK,
        EM_FINAL,
        EM_SGR
    } emit_t;

    typedef enum logic [2:0] {
        WM_NORM,
        WM_DEPTH,
        WM_INDEX,
        WM_RED,
        WM_GREEN,
        WM_BLUE
    } walk_mode_t;

    typedef struct packed {
        logic  clear_seq;
        logic  param_byte;
        logic  inter_byte;
        logic  final_push;
        logic  start_walk;
        logic  walk_step;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic byte_esc;
        logic byte_lbracket;
        logic byte_paren;
        logic byte_ignore;
        logic byte_param;
        logic byte_inter;
        logic byte_final;
        logic pbytes_full;
        logic inter_full;
        logic final_sgr;
        logic walk_last;
        logic out_blocked;
    } stat_t;

    function automatic logic [RGB_W-1:0] base16(input logic [3:0] idx);
        logic [RGB_W-1:0] c;
        begin
            case (idx)
                4'd0:    c = 24'h000000;
                4'd1:    c = 24'hC00000;
                4'd2:    c = 24'h00C000;
                4'd3:    c = 24'h808000;
                4'd4:    c = 24'h0000C0;
                4'd5:    c = 24'h800080;
                4'd6:    c = 24'h008080;
                4'd7:    c = 24'hC0C0C0;
                4'd8:    c = 24'h606060;
                4'd9:    c = 24'hFF0000;
                4'd10:   c = 24'h00FF00;
                4'd11:   c = 24'hFFFF00;
                4'd12:   c = 24'h0000FF;
                4'd13:   c = 24'hFF00FF;
                4'd14:   c = 24'h00FFFF;
                default: c = 24'hFFFFFF;
            endcase
            return c;
        end
    endfunction

    // 256-entry palette: base colors, 6x6x6 cube and grey ramp.
    function automatic logic [RGB_W-1:0] palette(input logic [ARG_W-1:0] idx);
        logic [7:0] k;
        logic [7:0] rem;
        logic [2:0] r6;
        logic [2:0] g6;
        logic [2:0] b6;
        logic [7:0] grey;
        logic [RGB_W-1:0] c;
        begin
            k    = idx[7:0] - 8'd16;
            r6   = (k >= 8'd180) ? 3'd5 : (k >= 8'd144) ? 3'd4 : (k >= 8'd108) ? 3'd3 :
                   (k >= 8'd72) ? 3'd2 : (k >= 8'd36) ? 3'd1 : 3'd0;
            rem  = k - 8'(r6) * 8'd36;
            g6   = (rem >= 8'd30) ? 3'd5 : (rem >= 8'd24) ? 3'd4 : (rem >= 8'd18) ? 3'd3 :
                   (rem >= 8'd12) ? 3'd2 : (rem >= 8'd6) ? 3'd1 : 3'd0;
            b6   = 3'(rem - 8'(g6) * 8'd6);
            grey = 8'((idx[7:0] - 8'd231) * 4'd10);
            if (idx > 16'd255)
                c = 24'h000000;
            else if (idx < 16'd16)
                c = base16(idx[3:0]);
            else if (idx < 16'd232)
                c = {8'(r6) * 8'd51, 8'(g6) * 8'd51, 8'(b6) * 8'd51};
            else
                c = {grey, grey, grey};
            return c;
        end
    endfunction

endpackage

// ===== hdl/asp_ctrl.sv =====
// ============================================================================
// ANSI parser controller
// Parse phase state machine; issues commands to the datapath.
// ============================================================================
module asp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  asp_pkg::stat_t st,
    output asp_pkg::cmd_t  cmd
);
    import asp_pkg::*;

    phase_t state_reg;
    phase_t state_next;
    logic   accept;

    assign in_stall = (state_reg == PH_WALK) | st.out_blocked;
    assign accept   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PH_GROUND;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PH_GROUND:
            begin
                if (accept && st.byte_esc)
                    state_next = PH_ESC;
            end
            PH_ESC:
            begin
                if (accept)
                    state_next = st.byte_lbracket ? PH_PARAM :
                                 st.byte_paren ? PH_SKIP : PH_GROUND;
            end
            PH_SKIP:
            begin
                if (accept)
                    state_next = PH_GROUND;
            end
            PH_PARAM, PH_INTER:
            begin
                if (accept)
                begin
                    if (state_reg == PH_PARAM && st.byte_param)
                        state_next = st.pbytes_full ? PH_GROUND : PH_PARAM;
                    else if (st.byte_inter)
                        state_next = st.inter_full ? PH_GROUND : PH_INTER;
                    else if (st.byte_final && st.final_sgr)
                        state_next = PH_WALK;
                    else
                        state_next = PH_GROUND;
                end
            end
            PH_WALK:
            begin
                if (st.walk_last)
                    state_next = PH_GROUND;
            end
            default: state_next = PH_GROUND;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.emit = EM_NONE;
        case (state_reg)
            PH_GROUND:
            begin
                if (accept)
                    cmd.emit = EM_GROUND;
            end
            PH_ESC:
            begin
                if (accept)
                begin
                    cmd.clear_seq = st.byte_lbracket;
                    if (!st.byte_lbracket && !st.byte_paren && !st.byte_ignore)
                        cmd.emit = EM_QMARK;
                end
            end
            PH_PARAM, PH_INTER:
            begin
                if (accept)
                begin
                    if (state_reg == PH_PARAM && st.byte_param)
                        cmd.param_byte = ~st.pbytes_full;
                    else if (st.byte_inter)
                        cmd.inter_byte = ~st.inter_full;
                    else if (st.byte_final)
                    begin
                        cmd.final_push = 1'b1;
                        cmd.start_walk = st.final_sgr;
                        if (!st.final_sgr)
                            cmd.emit = EM_FINAL;
                    end
                end
            end
            PH_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (st.walk_last)
                    cmd.emit = EM_SGR;
            end
            default: cmd.emit = EM_NONE;
        endcase
    end

endmodule

// ===== hdl/asp_datapath.sv =====
// ============================================================================
// ANSI parser datapath
// Parameter collection, command decode, SGR walk and the result register.
// ============================================================================
module asp_datapath
#(
    parameter int unsigned PARAM_BYTES_MAX  = 16,
    parameter int unsigned PARAM_SLOTS      = 8,
    parameter int unsigned INTERMEDIATE_MAX = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      in_byte,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [asp_pkg::DIM_W-1:0]       cfg_data,
    input  asp_pkg::cmd_t                   cmd,
    output asp_pkg::stat_t                  st,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [asp_pkg::CMD_W-1:0]       command,
    output logic [asp_pkg::ARG_W-1:0]       arg_first,
    output logic [asp_pkg::ARG_W-1:0]       arg_second,
    output logic [asp_pkg::GLYPH_W-1:0]     glyph,
    output logic [asp_pkg::RGB_W-1:0]       fg_rgb,
    output logic [asp_pkg::RGB_W-1:0]       bg_rgb,
    output logic                            bold,
    output logic                            italic,
    output logic                            underline
);
    import asp_pkg::*;

    localparam int unsigned SW = $clog2(PARAM_SLOTS + 1);
    localparam int unsigned IW = $clog2(PARAM_SLOTS);
    localparam int unsigned BW = $clog2(PARAM_BYTES_MAX + 1);
    localparam int unsigned NW = $clog2(INTERMEDIATE_MAX + 1);

    logic [DIM_W-1:0] cols_reg;
    logic [DIM_W-1:0] rows_reg;

    logic [ARG_W-1:0] store_reg [PARAM_SLOTS];
    logic [SW-1:0]    cnt_reg;
    logic [SW-1:0]    cnt_next;
    logic [BW-1:0]    pbytes_reg;
    logic [NW-1:0]    inter_reg;
    logic [ARG_W-1:0] acc_reg;
    logic [ARG_W-1:0] acc_next;
    logic             digits_reg;
    logic             digits_next;
    logic             nc_reg;
    logic [GLYPH_W-1:0] last_glyph_reg;

    logic [RGB_W-1:0] fg_reg;
    logic [RGB_W-1:0] fg_next;
    logic [RGB_W-1:0] bg_reg;
    logic [RGB_W-1:0] bg_next;
    logic [2:0]       attr_reg;
    logic [2:0]       attr_next;

    walk_mode_t       mode_reg;
    walk_mode_t       mode_next;
    logic [SW-1:0]    idx_reg;
    logic [SW-1:0]    num_reg;
    logic             isfg_reg;
    logic             isfg_next;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;

    logic             out_valid_reg;
    logic [CMD_W-1:0] cmd_out_reg;
    logic [ARG_W-1:0] a1_reg;
    logic [ARG_W-1:0] a2_reg;
    logic [GLYPH_W-1:0] gl_reg;
    logic [RGB_W-1:0] fgo_reg;
    logic [RGB_W-1:0] bgo_reg;
    logic [2:0]       attro_reg;

    // Byte classes.
    logic is_digit;
    logic is_printable;
    assign is_digit     = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign is_printable = (in_byte >= 8'h20) && (in_byte <= 8'h7E);

    // Accumulator update for a decimal digit, saturating at the top of range.
    logic [19:0] acc_mul;
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {16'd0, in_byte[3:0]};

    // Effective parameters seen by a final byte, including the pending value.
    logic          push_ok;
    logic [SW-1:0] cnt_eff;
    logic [SW-1:0] num_eff;
    logic [ARG_W-1:0] p0;
    logic [ARG_W-1:0] p1;
    assign push_ok = digits_reg && (cnt_reg < SW'(PARAM_SLOTS));
    assign cnt_eff = cnt_reg + SW'(push_ok);
    assign num_eff = (cnt_eff == '0) ? SW'(1) : cnt_eff;
    assign p0 = (cnt_reg != '0) ? store_reg[0] : (push_ok ? acc_reg : '0);
    assign p1 = (cnt_reg > SW'(1)) ? store_reg[1] :
                ((cnt_reg == SW'(1)) && push_ok) ? acc_reg : '0;

    logic final_common;
    assign final_common = ~nc_reg && !((in_byte >= 8'h70) && (in_byte <= 8'h7E));

    always_comb
    begin
        st.byte_esc      = (in_byte == 8'h1B);
        st.byte_lbracket = (in_byte == 8'h5B);
        st.byte_paren    = (in_byte == 8'h28) || (in_byte == 8'h29);
        st.byte_ignore   = (in_byte == 8'h3D) || (in_byte == 8'h3E) ||
                           (in_byte == 8'h0E) || (in_byte == 8'h0F);
        st.byte_param    = (in_byte >= 8'h30) && (in_byte <= 8'h3F);
        st.byte_inter    = (in_byte >= 8'h20) && (in_byte <= 8'h2F);
        st.byte_final    = (in_byte >= 8'h40) && (in_byte <= 8'h7E);
        st.pbytes_full   = (pbytes_reg >= BW'(PARAM_BYTES_MAX));
        st.inter_full    = (inter_reg >= NW'(INTERMEDIATE_MAX));
        st.final_sgr     = final_common && (in_byte == 8'h6D);
        st.walk_last     = (idx_reg + SW'(1)) >= num_reg;
        st.out_blocked   = out_valid_reg & out_stall;
    end

    // Result of a byte in the ground phase.
    logic             g_valid;
    logic [CMD_W-1:0] g_cmd;
    logic [GLYPH_W-1:0] g_glyph;
    always_comb
    begin
        g_valid = 1'b1;
        g_cmd   = CMD_GLYPH;
        g_glyph = '0;
        case (in_byte)
            8'h0D:   g_cmd = CMD_CR;
            8'h0A:   g_cmd = CMD_NL;
            8'h08:   g_cmd = CMD_BS;
            8'h09:   g_cmd = CMD_TAB;
            8'h07:   g_valid = 1'b0;
            8'h1B:   g_valid = 1'b0;
            default: g_glyph = is_printable ? in_byte[6:0] : GLYPH_UNKNOWN;
        endcase
    end

    // Result of a CSI final byte other than SGR.
    logic             f_valid;
    logic [CMD_W-1:0] f_cmd;
    logic [ARG_W-1:0] f_a1;
    logic [ARG_W-1:0] f_a2;
    logic [GLYPH_W-1:0] f_glyph;
    logic [ARG_W-1:0] p0_less;
    logic [ARG_W-1:0] p1_less;
    logic [ARG_W-1:0] p0_min1;
    assign p0_less = (p0 != '0) ? p0 - ARG_W'(1) : '0;
    assign p1_less = (p1 != '0) ? p1 - ARG_W'(1) : '0;
    assign p0_min1 = (p0 != '0) ? p0 : ARG_W'(1);

    always_comb
    begin
        f_valid = final_common;
        f_cmd   = CMD_GLYPH;
        f_a1    = '0;
        f_a2    = '0;
        f_glyph = '0;
        case (in_byte)
            8'h4A:
            begin
                if (p0 <= ARG_W'(3))
                begin
                    f_cmd = CMD_ED;
                    f_a1  = p0;
                end
                else
                    f_glyph = GLYPH_UNKNOWN;
            end
            8'h4B:
            begin
                if (p0 <= ARG_W'(2))
                begin
                    f_cmd = CMD_EL;
                    f_a1  = p0;
                end
                else
                    f_glyph = GLYPH_UNKNOWN;
            end
            8'h41: begin f_cmd = CMD_UP;     f_a1 = p0;      end
            8'h42: begin f_cmd = CMD_DOWN;   f_a1 = p0;      end
            8'h43: begin f_cmd = CMD_RIGHT;  f_a1 = p0;      end
            8'h44: begin f_cmd = CMD_LEFT;   f_a1 = p0;      end
            8'h47: begin f_cmd = CMD_COLUMN; f_a1 = p0_less; end
            8'h64: begin f_cmd = CMD_ROW;    f_a1 = p0_less; end
            8'h48, 8'h66:
            begin
                f_cmd = CMD_POS;
                f_a1  = p0_less;
                f_a2  = p1_less;
            end
            8'h53: f_cmd = CMD_NEXTLN;
            8'h6D: f_valid = 1'b0;
            8'h6E:
            begin
                f_cmd   = CMD_SIZE;
                f_a1    = ARG_W'(cols_reg);
                f_a2    = ARG_W'(rows_reg);
                f_valid = final_common && (num_eff == SW'(1)) && (p0 == ARG_W'(6));
            end
            8'h62:
            begin
                f_cmd   = CMD_REPEAT;
                f_a1    = p0;
                f_glyph = last_glyph_reg;
                f_valid = final_common && (p0 != '0);
            end
            8'h40: begin f_cmd = CMD_INSERT; f_a1 = p0_min1; end
            8'h50: begin f_cmd = CMD_DELCH;  f_a1 = p0_min1; end
            8'h4D: begin f_cmd = CMD_DELLN;  f_a1 = p0_min1; end
            default: f_glyph = GLYPH_UNKNOWN;
        endcase
    end

    // SGR walk: one stored parameter per cycle.
    logic [ARG_W-1:0] n;
    logic             more1;
    logic             more3;
    logic [RGB_W-1:0] ext_color;
    logic             ext_set;
    assign n     = (idx_reg < cnt_reg) ? store_reg[idx_reg[IW-1:0]] : '0;
    assign more1 = ({1'b0, idx_reg} + (SW+1)'(1)) < {1'b0, num_reg};
    assign more3 = ({1'b0, idx_reg} + (SW+1)'(3)) < {1'b0, num_reg};

    always_comb
    begin
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        attr_next = attr_reg;
        mode_next = mode_reg;
        isfg_next = isfg_reg;
        ext_set   = 1'b0;
        ext_color = palette(n);
        if (cmd.walk_step)
        begin
            case (mode_reg)
                WM_NORM:
                begin
                    if (n == 16'd0)
                    begin
                        fg_next   = FG_DEFAULT;
                        bg_next   = BG_DEFAULT;
                        attr_next = '0;
                    end
                    else if (n == 16'd1)  attr_next[0] = 1'b1;
                    else if (n == 16'd3)  attr_next[1] = 1'b1;
                    else if (n == 16'd4)  attr_next[2] = 1'b1;
                    else if (n == 16'd7)
                    begin
                        fg_next = bg_reg;
                        bg_next = fg_reg;
                    end
                    else if (n == 16'd22) attr_next[0] = 1'b0;
                    else if (n == 16'd23) attr_next[1] = 1'b0;
                    else if (n == 16'd24) attr_next[2] = 1'b0;
                    else if (n == 16'd39) fg_next = FG_DEFAULT;
                    else if (n == 16'd49) bg_next = BG_DEFAULT;
                    else if (n >= 16'd30 && n <= 16'd37) fg_next = base16({1'b0, n[2:0] + 3'd2});
                    else if (n >= 16'd40 && n <= 16'd47) bg_next = base16({1'b0, n[2:0]});
                    else if (n >= 16'd90 && n <= 16'd97) fg_next = base16({1'b1, n[2:0] + 3'd6});
                    else if (n >= 16'd100 && n <= 16'd107)
                        bg_next = base16({1'b1, n[2:0] + 3'd4});
                    else if ((n == 16'd38 || n == 16'd48) && more1)
                    begin
                        mode_next = WM_DEPTH;
                        isfg_next = (n == 16'd38);
                    end
                end
                WM_DEPTH:
                begin
                    if (n == 16'd5 && more1)
                        mode_next = WM_INDEX;
                    else if (n == 16'd2 && more3)
                        mode_next = WM_RED;
                    else
                        mode_next = WM_NORM;
                end
                WM_INDEX:
                begin
                    ext_set   = 1'b1;
                    mode_next = WM_NORM;
                end
                WM_RED:   mode_next = WM_GREEN;
                WM_GREEN: mode_next = WM_BLUE;
                WM_BLUE:
                begin
                    ext_color = {red_reg, green_reg, n[7:0]};
                    ext_set   = 1'b1;
                    mode_next = WM_NORM;
                end
                default: mode_next = WM_NORM;
            endcase
            if (ext_set)
            begin
                if (isfg_reg)
                    fg_next = ext_color;
                else
                    bg_next = ext_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mode_reg == WM_RED)
            red_reg <= n[7:0];
        if (mode_reg == WM_GREEN)
            green_reg <= n[7:0];
        isfg_reg <= isfg_next;
    end

    // Parameter collection.
    always_comb
    begin
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        if (cmd.clear_seq)
        begin
            cnt_next    = '0;
            acc_next    = '0;
            digits_next = 1'b0;
        end
        else if (cmd.param_byte)
        begin
            if (is_digit)
            begin
                acc_next    = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
                digits_next = 1'b1;
            end
            else if (in_byte == 8'h3B)
            begin
                cnt_next    = cnt_eff;
                acc_next    = '0;
                digits_next = 1'b0;
            end
        end
        else if (cmd.final_push)
        begin
            cnt_next    = cnt_eff;
            acc_next    = '0;
            digits_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.final_push || (cmd.param_byte && in_byte == 8'h3B)) && push_ok)
            store_reg[cnt_reg[IW-1:0]] <= acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg       <= DIM_W'(80);
            rows_reg       <= DIM_W'(25);
            cnt_reg        <= '0;
            pbytes_reg     <= '0;
            inter_reg      <= '0;
            acc_reg        <= '0;
            digits_reg     <= 1'b0;
            nc_reg         <= 1'b0;
            last_glyph_reg <= '0;
            fg_reg         <= FG_DEFAULT;
            bg_reg         <= BG_DEFAULT;
            attr_reg       <= '0;
            mode_reg       <= WM_NORM;
            idx_reg        <= '0;
            num_reg        <= SW'(1);
        end
        else
        begin
            if (cfg_we && cfg_index == REG_COLUMNS)
                cols_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_ROWS)
                rows_reg <= cfg_data;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            if (cmd.clear_seq)
            begin
                pbytes_reg <= '0;
                inter_reg  <= '0;
                nc_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.param_byte)
                begin
                    pbytes_reg <= pbytes_reg + BW'(1);
                    if (!is_digit && in_byte != 8'h3B)
                        nc_reg <= 1'b1;
                end
                if (cmd.inter_byte)
                    inter_reg <= inter_reg + NW'(1);
            end
            if (cmd.emit == EM_GROUND && is_printable)
                last_glyph_reg <= in_byte[6:0];
            fg_reg   <= fg_next;
            bg_reg   <= bg_next;
            attr_reg <= attr_next;
            if (cmd.start_walk)
            begin
                mode_reg <= WM_NORM;
                idx_reg  <= '0;
                num_reg  <= num_eff;
            end
            else if (cmd.walk_step)
            begin
                mode_reg <= mode_next;
                idx_reg  <= idx_reg + SW'(1);
            end
        end
    end

    // Result register.
    logic load;
    always_comb
    begin
        case (cmd.emit)
            EM_GROUND: load = g_valid;
            EM_QMARK:  load = 1'b1;
            EM_FINAL:  load = f_valid;
            EM_SGR:    load = 1'b1;
            default:   load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fgo_reg   <= fg_next;
            bgo_reg   <= bg_next;
            attro_reg <= attr_next;
            case (cmd.emit)
                EM_GROUND:
                begin
                    cmd_out_reg <= g_cmd;
                    a1_reg      <= '0;
                    a2_reg      <= '0;
                    gl_reg      <= g_glyph;
                end
                EM_FINAL:
                begin
                    cmd_out_reg <= f_cmd;
                    a1_reg      <= f_a1;
                    a2_reg      <= f_a2;
                    gl_reg      <= f_glyph;
                end
                EM_SGR:
                begin
                    cmd_out_reg <= CMD_ATTR;
                    a1_reg      <= '0;
                    a2_reg      <= '0;
                    gl_reg      <= '0;
                end
                default:
                begin
                    cmd_out_reg <= CMD_GLYPH;
                    a1_reg      <= '0;
                    a2_reg      <= '0;
                    gl_reg      <= GLYPH_UNKNOWN;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign command    = cmd_out_reg;
    assign arg_first  = a1_reg;
    assign arg_second = a2_reg;
    assign glyph      = gl_reg;
    assign fg_rgb     = fgo_reg;
    assign bg_rgb     = bgo_reg;
    assign bold       = attro_reg[0];
    assign italic     = attro_reg[1];
    assign underline  = attro_reg[2];

endmodule

// ===== hdl/ansi_escape_sequence_parser_top.sv =====
// ============================================================================
// ANSI escape sequence parser, top level
// Decodes a terminal output byte stream into screen commands with attributes.
// ============================================================================
// A result is registered and visible in the cycle after the byte beat that causes it;
// an SGR result is loaded only once the walk over its parameters (1 to PARAM_SLOTS) ends.
// Throughput: one byte per cycle, except that an SGR final byte holds the input
// for that walk, and a waiting result beat holds it until taken downstream.
// Reset: asynchronous, active low; parser returns to ground, colors to
// light grey on black, screen size to 80 by 25.
module ansi_escape_sequence_parser_top
#(
    parameter int unsigned PARAM_BYTES_MAX  = 16,
    parameter int unsigned PARAM_SLOTS      = 8,
    parameter int unsigned INTERMEDIATE_MAX = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [asp_pkg::CMD_W-1:0]       command,
    output logic [asp_pkg::ARG_W-1:0]       arg_first,
    output logic [asp_pkg::ARG_W-1:0]       arg_second,
    output logic [asp_pkg::GLYPH_W-1:0]     glyph,
    output logic [asp_pkg::RGB_W-1:0]       fg_rgb,
    output logic [asp_pkg::RGB_W-1:0]       bg_rgb,
    output logic                            bold,
    output logic                            italic,
    output logic                            underline,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [asp_pkg::DIM_W-1:0]       cfg_data
);
    import asp_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // Configuration writes are always taken; they are written straight into the size registers.
    assign cfg_ready = 1'b1;

    // The controller walks the parse phases and tells the datapath what to
    // do with each accepted byte beat.
    asp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds parameters, colors and the output register.
    asp_datapath
    #(
        .PARAM_BYTES_MAX  (PARAM_BYTES_MAX),
        .PARAM_SLOTS      (PARAM_SLOTS),
        .INTERMEDIATE_MAX (INTERMEDIATE_MAX)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .command    (command),
        .arg_first  (arg_first),
        .arg_second (arg_second),
        .glyph      (glyph),
        .fg_rgb     (fg_rgb),
        .bg_rgb     (bg_rgb),
        .bold       (bold),
        .italic     (italic),
        .underline  (underline)
    );

endmodule

// ===== hdl/asp_checker.sv =====
// ============================================================================
// ANSI parser port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
module asp_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [asp_pkg::CMD_W-1:0]   command,
    input logic [asp_pkg::ARG_W-1:0]   arg_second,
    input logic                        cfg_ready
);
    import asp_pkg::*;

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command))
    else $error("stalled result beat changed");

    // No new byte is taken while a result waits downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
    else $error("input accepted while output blocked");

    // Only positioning and size reports carry a second argument.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != CMD_POS && command != CMD_SIZE |-> arg_second == '0)
    else $error("unexpected second argument");

    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind ansi_escape_sequence_parser_top asp_checker u_asp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .arg_second (arg_second),
    .cfg_ready  (cfg_ready)
);
